[sv/tgd_pkg.sv]
package tgd_pkg;

	localparam int TIME_BITS = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int HELD_W = 16;
	localparam int QUEUE_DEPTH = 3;
	localparam int QCNT_W = 2;

	typedef enum logic [1:0] {
		EV_TOUCH   = 2'd0,
		EV_LONG    = 2'd1,
		EV_RELEASE = 2'd2,
		EV_DOUBLE  = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOUCH_THRESHOLD  = 2'd0,
		CFG_POLL_PERIOD_MS   = 2'd1,
		CFG_LONG_TOUCH_MS    = 2'd2,
		CFG_DOUBLE_WINDOW_US = 2'd3
	} cfg_idx_t;

	localparam logic [15:0] RST_TOUCH_THRESHOLD = 16'd500;
	localparam logic [15:0] RST_POLL_PERIOD_MS = 16'd100;
	localparam logic [15:0] RST_LONG_TOUCH_MS = 16'd3000;
	localparam logic [31:0] RST_DOUBLE_WINDOW_US = 32'd1000000;

	typedef struct packed {
		logic [15:0] touch_threshold;
		logic [15:0] poll_period_ms;
		logic [15:0] long_touch_ms;
		logic [31:0] double_window_us;
	} cfg_t;

	typedef struct packed {
		logic                 is_touched;
		logic [HELD_W-1:0]    held_ms;
		logic                 short_sent;
		logic                 long_sent;
		logic [TIME_BITS-1:0] prev_release_us;
	} gest_state_t;

	typedef struct packed {
		event_t code;
		logic   last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    res0;
		result_t    res1;
	} eval_t;

endpackage

[sv/tgd_eval.sv]
module tgd_eval (
	input  tgd_pkg::cfg_t                  cfg,
	input  tgd_pkg::gest_state_t           cur,
	input  logic [15:0]                    sample,
	input  logic [tgd_pkg::TIME_BITS-1:0]  now_us,
	output tgd_pkg::gest_state_t           nxt,
	output tgd_pkg::eval_t                 ev
);
	import tgd_pkg::*;

	logic [HELD_W:0]       sum;
	logic [HELD_W-1:0]     held_new;
	logic                  touched;
	logic [TIME_BITS-1:0]  gap;
	logic                  in_window;

	assign touched = sample < cfg.touch_threshold;
	assign sum = {1'b0, cur.held_ms} + {1'b0, cfg.poll_period_ms};
	assign held_new = sum[HELD_W] ? {HELD_W{1'b1}} : sum[HELD_W-1:0];
	assign gap = now_us - cur.prev_release_us;
	// a timestamp behind the recorded release counts as a negative gap
	assign in_window = (now_us < cur.prev_release_us) ||
		(gap < {{(TIME_BITS-32){1'b0}}, cfg.double_window_us});

	always_comb begin
		nxt = cur;
		ev.count = 2'd0;
		ev.res0 = '{code: EV_RELEASE, last: 1'b1};
		ev.res1 = '{code: EV_DOUBLE, last: 1'b1};
		if (touched) begin
			nxt.is_touched = 1'b1;
			nxt.held_ms = held_new;
			if (held_new >= cfg.long_touch_ms) begin
				if (!cur.long_sent) begin
					nxt.long_sent = 1'b1;
					ev.count = 2'd1;
					ev.res0 = '{code: EV_LONG, last: 1'b1};
				end
			end else if (!cur.short_sent) begin
				nxt.short_sent = 1'b1;
				ev.count = 2'd1;
				ev.res0 = '{code: EV_TOUCH, last: 1'b1};
			end
		end else if (cur.is_touched) begin
			nxt.is_touched = 1'b0;
			nxt.held_ms = '0;
			nxt.short_sent = 1'b0;
			nxt.long_sent = 1'b0;
			if (in_window) begin
				nxt.prev_release_us = '0;
				ev.count = 2'd2;
				ev.res0 = '{code: EV_RELEASE, last: 1'b0};
			end else begin
				nxt.prev_release_us = now_us;
				ev.count = 2'd1;
			end
		end
	end

endmodule

[sv/touch_gesture_detector_core.sv]
// Touch gesture detector. Each input transaction is one touch-pad poll (raw
// count and microsecond timestamp); each output transaction is one event:
// touch, long touch, release or double touch, with last set on the final
// event of a poll. A poll is captured in an input register and evaluated from
// it once the three-entry result queue holds at most one event; its events are
// written into the queue, whose head is offered on the output port. A poll is
// accepted in every cycle while the queue holds at most one event; a release
// that forms a double touch yields two events, and the single output port,
// one event per cycle while out_stall is low, sets the sustained rate.
// Configuration writes take effect at once and are meant for idle periods.
module touch_gesture_detector_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [15:0]                    sample,
	input  logic [tgd_pkg::TIME_BITS-1:0]  now_us,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     event_code,
	output logic                           last,
	input  logic                           cfg_we,
	input  logic [tgd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tgd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tgd_pkg::*;

	cfg_t                 cfg_q;
	gest_state_t          state_q;
	gest_state_t          state_nxt;
	eval_t                ev;
	logic                 valid_s1;
	logic [15:0]          sample_s1;
	logic [TIME_BITS-1:0] now_s1;
	logic                 advance;
	logic                 in_accept;
	logic                 pop;
	result_t              queue_q [QUEUE_DEPTH];
	result_t              queue_nxt [QUEUE_DEPTH];
	logic [QCNT_W-1:0]    count_q;
	logic [QCNT_W-1:0]    count_pop;
	logic [QCNT_W-1:0]    count_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.touch_threshold <= RST_TOUCH_THRESHOLD;
			cfg_q.poll_period_ms <= RST_POLL_PERIOD_MS;
			cfg_q.long_touch_ms <= RST_LONG_TOUCH_MS;
			cfg_q.double_window_us <= RST_DOUBLE_WINDOW_US;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TOUCH_THRESHOLD:  cfg_q.touch_threshold <= cfg_data[15:0];
				CFG_POLL_PERIOD_MS:   cfg_q.poll_period_ms <= cfg_data[15:0];
				CFG_LONG_TOUCH_MS:    cfg_q.long_touch_ms <= cfg_data[15:0];
				CFG_DOUBLE_WINDOW_US: cfg_q.double_window_us <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// evaluate only when the queue has room for a double touch
	assign advance = (count_q <= QCNT_W'(1));
	assign in_stall = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_s1 <= sample;
			now_s1 <= now_us;
		end
	end

	tgd_eval u_eval (
		.cfg    (cfg_q),
		.cur    (state_q),
		.sample (sample_s1),
		.now_us (now_s1),
		.nxt    (state_nxt),
		.ev     (ev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (valid_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	assign out_valid = (count_q != '0);
	assign pop = out_valid && !out_stall;
	assign count_pop = count_q - QCNT_W'(pop);

	always_comb begin
		count_nxt = count_pop;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (pop && i < QUEUE_DEPTH - 1) begin
				queue_nxt[i] = queue_q[i + 1];
			end else begin
				queue_nxt[i] = queue_q[i];
			end
		end
		if (valid_s1 && advance) begin
			if (ev.count != 2'd0) begin
				queue_nxt[count_pop] = ev.res0;
			end
			if (ev.count == 2'd2) begin
				queue_nxt[count_pop + QCNT_W'(1)] = ev.res1;
			end
			count_nxt = count_pop + QCNT_W'(ev.count);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		queue_q <= queue_nxt;
	end

	assign event_code = queue_q[0].code;
	assign last = queue_q[0].last;

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_code) && $stable(last)))
		else $error("stalled output transaction changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> (count_q >= QCNT_W'(2) &&
			queue_q[0].code == EV_RELEASE && queue_q[1].code == EV_DOUBLE))
		else $error("release not followed by double touch");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && count_q >= QCNT_W'(2)))
		else $error("input stalled with room in the queue");

	assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.is_touched |-> (!state_q.short_sent && !state_q.long_sent &&
			state_q.held_ms == '0))
		else $error("gesture flags set while untouched");

endmodule

[tb/sv/tb_touch_gesture_detector_core.sv]
module tb_touch_gesture_detector_core;
	import tgd_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [15:0]           sample = '0;
	logic [TIME_BITS-1:0]  now_us = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [1:0]            event_code;
	logic                  last;
	logic                  cfg_we = 1'b0;
	cfg_idx_t              cfg_index = CFG_TOUCH_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	touch_gesture_detector_core u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.now_us     (now_us),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_code (event_code),
		.last       (last),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// gesture tracker: settings and press state as the block should hold them
	logic [15:0]          thr_cnt;
	logic [15:0]          period_ms;
	logic [15:0]          long_ms;
	logic [31:0]          window_us;
	logic                 pad_down;
	logic [15:0]          held_ms;
	logic                 touch_reported;
	logic                 long_reported;
	logic [TIME_BITS-1:0] last_release_us;

	result_t        pending_events[$];
	result_t        want;
	int             mismatches = 0;
	int             quiet_cycles = 0;
	int             idle_pct = 0;
	int             stall_pct = 0;
	logic [TIME_BITS-1:0] pad_clock_us = '0;

	initial begin
		forever #4 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < stall_pct);
	end

	// returns 1 when the poll is not simply ignored by the block
	function automatic bit predict_gestures(input logic [15:0] s, input logic [TIME_BITS-1:0] t);
		logic [16:0] sum;
		if (s < thr_cnt) begin
			sum = {1'b0, held_ms} + {1'b0, period_ms};
			pad_down = 1'b1;
			held_ms = sum[16] ? 16'hFFFF : sum[15:0];
			if (held_ms >= long_ms) begin
				if (!long_reported) begin
					long_reported = 1'b1;
					pending_events.push_back('{code: EV_LONG, last: 1'b1});
				end
			end else if (!touch_reported) begin
				touch_reported = 1'b1;
				pending_events.push_back('{code: EV_TOUCH, last: 1'b1});
			end
			return 1'b1;
		end
		if (!pad_down)
			return 1'b0;
		pad_down = 1'b0;
		held_ms = '0;
		touch_reported = 1'b0;
		long_reported = 1'b0;
		// a timestamp behind the recorded release counts as a negative gap
		if (t < last_release_us || (t - last_release_us) < TIME_BITS'(window_us)) begin
			last_release_us = '0;
			pending_events.push_back('{code: EV_RELEASE, last: 1'b0});
			pending_events.push_back('{code: EV_DOUBLE, last: 1'b1});
		end else begin
			last_release_us = t;
			pending_events.push_back('{code: EV_RELEASE, last: 1'b1});
		end
		return 1'b1;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event: expected none, got code %0d last %0b",
					$time, event_code, last);
				mismatches++;
			end else begin
				want = pending_events.pop_front();
				if (event_code !== want.code) begin
					$display("%0t: event_code mismatch: expected %0d, got %0d",
						$time, want.code, event_code);
					mismatches++;
				end
				if (last !== want.last) begin
					$display("%0t: last mismatch: expected %0b, got %0b",
						$time, want.last, last);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_poll(input logic [15:0] s, input logic [TIME_BITS-1:0] t,
			output bit counted);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		sample = s;
		now_us = t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		counted = predict_gestures(s, t);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		// a poll with no event may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		wait_drained();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		case (idx)
			CFG_TOUCH_THRESHOLD:  thr_cnt = value[15:0];
			CFG_POLL_PERIOD_MS:   period_ms = value[15:0];
			CFG_LONG_TOUCH_MS:    long_ms = value[15:0];
			CFG_DOUBLE_WINDOW_US: window_us = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_release_near_reset();
		bit c;
		send_poll(16'd100, 48'd0, c);
		// recorded release is still zero, so this one pairs with it
		send_poll(16'd600, 48'd10, c);
		send_poll(16'd600, 48'd20, c);
		send_poll(16'd500, 48'd30, c);
		send_poll(16'd499, 48'd40, c);
		send_poll(16'd500, 48'd2_000_000, c);
	endtask

	task automatic test_press_timing();
		bit c;
		write_reg(CFG_LONG_TOUCH_MS, 32'd300);
		repeat (4) send_poll(16'd0, 48'd3_000_000, c);
		send_poll(16'd1000, 48'd3_500_000, c);
		send_poll(16'd0, 48'd3_600_000, c);
		send_poll(16'd1000, 48'd4_000_000, c);
		send_poll(16'd0, 48'd4_100_000, c);
		send_poll(16'd1000, 48'd1_500_000, c);
	endtask

	task automatic test_register_extremes();
		bit c;
		write_reg(CFG_TOUCH_THRESHOLD, 32'd0);
		send_poll(16'd0, 48'd1_600_000, c);
		write_reg(CFG_TOUCH_THRESHOLD, 32'hFFFF_FFFF);
		send_poll(16'd65534, 48'd1_700_000, c);
		write_reg(CFG_POLL_PERIOD_MS, 32'h0000_FFFF);
		send_poll(16'd0, 48'd1_800_000, c);
		write_reg(CFG_LONG_TOUCH_MS, 32'h0000_FFFF);
		send_poll(16'd0, 48'd1_900_000, c);
		send_poll(16'd65535, 48'hFFFF_FFFF_FFFF, c);
		write_reg(CFG_DOUBLE_WINDOW_US, 32'hFFFF_FFFF);
		write_reg(CFG_POLL_PERIOD_MS, 32'd0);
		write_reg(CFG_LONG_TOUCH_MS, 32'd0);
		send_poll(16'd0, 48'd0, c);
		send_poll(16'd65535, 48'd0, c);
		write_reg(CFG_LONG_TOUCH_MS, 32'd1);
		send_poll(16'd0, 48'd1, c);
		send_poll(16'd0, 48'd2, c);
		write_reg(CFG_DOUBLE_WINDOW_US, 32'd1);
		send_poll(16'd65535, 48'd5, c);
		send_poll(16'd0, 48'd6, c);
		send_poll(16'd65535, 48'd5, c);
	endtask

	task automatic randomize_settings();
		int pick;
		logic [31:0] lim;
		pick = $urandom_range(9);
		write_reg(CFG_TOUCH_THRESHOLD, {16'($urandom_range(65535)),
			pick == 0 ? 16'hFFFF : pick == 1 ? 16'd1 : 16'($urandom_range(65535, 2))});
		pick = $urandom_range(9);
		write_reg(CFG_POLL_PERIOD_MS, {16'($urandom_range(65535)),
			pick == 0 ? 16'd0 : pick == 1 ? 16'hFFFF : 16'($urandom_range(2000, 1))});
		pick = $urandom_range(9);
		lim = period_ms * $urandom_range(10, 0);
		if (pick == 0 || lim > 32'hFFFF)
			lim = (pick == 0) ? 32'd0 : 32'hFFFF;
		else if (pick == 1)
			lim = 32'hFFFF;
		write_reg(CFG_LONG_TOUCH_MS, {16'($urandom_range(65535)), lim[15:0]});
		pick = $urandom_range(9);
		write_reg(CFG_DOUBLE_WINDOW_US, pick == 0 ? 32'd1 : pick == 1 ? 32'hFFFF_FFFF :
			pick == 2 ? $urandom : $urandom_range(5_000_000, 1));
	endtask

	task automatic test_random_traffic(input int idle, input int stall, input int polls);
		int done;
		int len;
		int roll;
		bit c;
		logic [63:0] span;
		idle_pct = idle;
		stall_pct = stall;
		repeat (2) begin
			randomize_settings();
			done = 0;
			while (done < polls / 2) begin
				roll = $urandom_range(99);
				if (roll < 85) begin
					// well-formed press and release; short gaps favor double touches
					span = $urandom_range(1) ? {32'd0, window_us} >> 3 :
						{31'd0, window_us, 1'b0};
					len = $urandom_range(12, 1);
					repeat (len) begin
						pad_clock_us += TIME_BITS'(rand64() % (span + 1));
						send_poll(16'($urandom_range(thr_cnt - 1, 0)), pad_clock_us, c);
						done += c;
					end
					pad_clock_us += TIME_BITS'(rand64() % (span + 1));
					send_poll(16'($urandom_range(65535, thr_cnt)), pad_clock_us, c);
					done += c;
				end else begin
					// noise: any count at any time, forward or backward
					pad_clock_us = TIME_BITS'(rand64());
					send_poll(16'($urandom), pad_clock_us, c);
					done += c;
				end
			end
		end
	endtask

	initial begin
		thr_cnt = RST_TOUCH_THRESHOLD;
		period_ms = RST_POLL_PERIOD_MS;
		long_ms = RST_LONG_TOUCH_MS;
		window_us = RST_DOUBLE_WINDOW_US;
		pad_down = 1'b0;
		held_ms = '0;
		touch_reported = 1'b0;
		long_reported = 1'b0;
		last_release_us = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_release_near_reset();
		test_press_timing();
		test_register_extremes();
		test_random_traffic(0, 0, 450);
		test_random_traffic(49, 0, 450);
		test_random_traffic(0, 49, 450);
		test_random_traffic(7, 7, 450);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0t: %0d mismatches, %0d events never seen", $time, mismatches,
				pending_events.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

[touch_gesture_detector_core.f]
sv/tgd_pkg.sv
sv/tgd_eval.sv
sv/touch_gesture_detector_core.sv
tb/sv/tb_touch_gesture_detector_core.sv
